// ----- rtl/dsb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsb_pkg
// Shared types and codes of the depth sorted sprite batcher.
// ----------------------------------------------------------------------------
package dsb_pkg;

  // request command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_ENTRY    = 2'd2,
    KIND_EMPTY    = 2'd3
  } kind_e;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_DRAIN = 1'b1
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic insert;       // store the request entry, report accepted
    logic refuse;       // report full, buffer unchanged
    logic drain_empty;  // report drain of an empty buffer
    logic pop;          // emit head entry and shift the buffer up
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;     // result register can load this cycle
    logic empty;
    logic full;
    logic count_one;    // exactly one entry held
  } status_t;

endpackage

// ----- rtl/dsb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsb_if
// Request and result channel interfaces, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dsb_req_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] depth_key;
  logic signed [31:0] height_key;
  logic        [15:0] texture_id;
  logic        [15:0] entry_tag;

  modport source (output valid, cmd, depth_key, height_key, texture_id, entry_tag,
                  input ready);
  modport sink   (input valid, cmd, depth_key, height_key, texture_id, entry_tag,
                  output ready);
endinterface

interface dsb_res_if #(
  parameter int OCC_W = 7
);
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic signed [31:0] out_depth;
  logic signed [31:0] out_height;
  logic        [15:0] out_texture;
  logic        [15:0] out_tag;
  logic               run_end;
  logic [OCC_W-1:0]   occupancy;
  logic               last;

  modport source (output valid, kind, out_depth, out_height, out_texture, out_tag,
                  run_end, occupancy, last, input ready);
  modport sink   (input valid, kind, out_depth, out_height, out_texture, out_tag,
                  run_end, occupancy, last, output ready);
endinterface

// ----- rtl/dsb_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsb_datapath
// Sorted shift-register cells, entry count and result register.
// ----------------------------------------------------------------------------
module dsb_datapath #(
  parameter int BUFFER_DEPTH = 64,
  parameter int CNT_W        = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dsb_pkg::cmd_t      cmd_i,
  input  logic signed [31:0] depth_i,
  input  logic signed [31:0] height_i,
  input  logic        [15:0] texture_i,
  input  logic        [15:0] tag_i,
  input  logic               out_ready_i,
  output dsb_pkg::status_t   status_o,
  output logic               out_valid_o,
  output logic        [1:0]  kind_o,
  output logic signed [31:0] depth_o,
  output logic signed [31:0] height_o,
  output logic        [15:0] texture_o,
  output logic        [15:0] tag_o,
  output logic               run_end_o,
  output logic [CNT_W-1:0]   occupancy_o,
  output logic               last_o
);

  logic signed [31:0] depth_q   [BUFFER_DEPTH];
  logic signed [31:0] height_q  [BUFFER_DEPTH];
  logic        [15:0] texture_q [BUFFER_DEPTH];
  logic        [15:0] tag_q     [BUFFER_DEPTH];

  logic [CNT_W-1:0] count_q, count_d;

  // go marks a slot at or after the insert position (empty slot or outranked entry)
  logic [BUFFER_DEPTH-1:0] go;
  logic [BUFFER_DEPTH-1:0] go_prev;

  always_comb begin
    for (int i = 0; i < BUFFER_DEPTH; i++) begin
      go[i] = (CNT_W'(i) >= count_q) ||
              (depth_i > depth_q[i]) ||
              ((depth_i == depth_q[i]) && (height_i > height_q[i]));
    end
    go_prev = {go[BUFFER_DEPTH-2:0], 1'b0};
  end

  for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (cmd_i.insert && go[i]) begin
        if (!go_prev[i]) begin
          depth_q[i]   <= depth_i;
          height_q[i]  <= height_i;
          texture_q[i] <= texture_i;
          tag_q[i]     <= tag_i;
        end else if (i > 0) begin
          depth_q[i]   <= depth_q[(i > 0) ? i - 1 : 0];
          height_q[i]  <= height_q[(i > 0) ? i - 1 : 0];
          texture_q[i] <= texture_q[(i > 0) ? i - 1 : 0];
          tag_q[i]     <= tag_q[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd_i.pop && (i < BUFFER_DEPTH - 1)) begin
        depth_q[i]   <= depth_q[(i < BUFFER_DEPTH - 1) ? i + 1 : i];
        height_q[i]  <= height_q[(i < BUFFER_DEPTH - 1) ? i + 1 : i];
        texture_q[i] <= texture_q[(i < BUFFER_DEPTH - 1) ? i + 1 : i];
        tag_q[i]     <= tag_q[(i < BUFFER_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // result register
  logic               valid_q;
  logic        [1:0]  kind_q;
  logic signed [31:0] rdepth_q, rheight_q;
  logic        [15:0] rtex_q, rtag_q;
  logic               rend_q, last_q;
  logic [CNT_W-1:0]   occ_q;
  logic               load;

  assign load = cmd_i.insert | cmd_i.refuse | cmd_i.drain_empty | cmd_i.pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rdepth_q  <= '0;
      rheight_q <= '0;
      rtex_q    <= '0;
      rtag_q    <= '0;
      rend_q    <= 1'b0;
      last_q    <= 1'b1;
      occ_q     <= '0;
      kind_q    <= dsb_pkg::KIND_EMPTY;
      if (cmd_i.insert) begin
        kind_q <= dsb_pkg::KIND_ACCEPTED;
        occ_q  <= count_q + CNT_W'(1);
      end else if (cmd_i.refuse) begin
        kind_q <= dsb_pkg::KIND_FULL;
        occ_q  <= CNT_W'(BUFFER_DEPTH);
      end else if (cmd_i.pop) begin
        kind_q    <= dsb_pkg::KIND_ENTRY;
        rdepth_q  <= depth_q[0];
        rheight_q <= height_q[0];
        rtex_q    <= texture_q[0];
        rtag_q    <= tag_q[0];
        rend_q    <= status_o.count_one || (texture_q[1] != texture_q[0]);
        last_q    <= status_o.count_one;
      end
    end
  end

  assign status_o.out_free  = !valid_q || out_ready_i;
  assign status_o.empty     = (count_q == '0);
  assign status_o.full      = (count_q == CNT_W'(BUFFER_DEPTH));
  assign status_o.count_one = (count_q == CNT_W'(1));

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign depth_o     = rdepth_q;
  assign height_o    = rheight_q;
  assign texture_o   = rtex_q;
  assign tag_o       = rtag_q;
  assign run_end_o   = rend_q;
  assign occupancy_o = occ_q;
  assign last_o      = last_q;

endmodule

// ----- rtl/dsb_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsb_controller
// Request acceptance and drain sequencing.
// ----------------------------------------------------------------------------
module dsb_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_cmd_i,
  input  dsb_pkg::status_t status_i,
  output logic             in_ready_o,
  output dsb_pkg::cmd_t    cmd_o
);

  dsb_pkg::state_e state_q, state_d;
  logic            acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsb_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dsb_pkg::S_IDLE: begin
        if (acc && (in_cmd_i == dsb_pkg::CMD_DRAIN) && !status_i.empty) begin
          state_d = dsb_pkg::S_DRAIN;
        end
      end
      dsb_pkg::S_DRAIN: begin
        if (status_i.out_free && status_i.count_one) begin
          state_d = dsb_pkg::S_IDLE;
        end
      end
      default: state_d = dsb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = (state_q == dsb_pkg::S_IDLE) && status_i.out_free;
    acc               = in_valid_i && in_ready_o;
    cmd_o.insert      = acc && (in_cmd_i == dsb_pkg::CMD_INSERT) && !status_i.full;
    cmd_o.refuse      = acc && (in_cmd_i == dsb_pkg::CMD_INSERT) && status_i.full;
    cmd_o.drain_empty = acc && (in_cmd_i == dsb_pkg::CMD_DRAIN) && status_i.empty;
    cmd_o.pop         = (state_q == dsb_pkg::S_DRAIN) && status_i.out_free;
  end

endmodule

// ----- rtl/depth_sorted_sprite_batcher_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_sorted_sprite_batcher_unit
// Sprite buffer kept sorted by depth then height, drained in order.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per handshake: an insert (cmd 0) with the
//   sprite keys, texture and tag, or a drain (cmd 1). res_o returns results.
//   An insert gives one result (accepted with the new occupancy, or refused
//   when BUFFER_DEPTH entries are held). A drain gives one result per held
//   entry, largest depth first, then largest height, equal keys in arrival
//   order, with run_end where the texture changes and last on the final
//   one; a drain of an empty buffer gives a single empty result.
// Timing:
//   An insert or an empty drain loads the result register at the edge that
//   takes the request. Inserts sustain one per cycle while the receiver
//   takes each result: every cell compares against the new key in
//   parallel and the lower part of the row shifts down in one step.
//   A drain pops its first entry in the cycle after the request is taken,
//   then one entry per cycle from the head cell while the receiver keeps
//   up; no request is taken until the last pop is done.
// Reset clears the entry count and the result valid; cell contents are
// left as they are. A stalled receiver holds the result register, and the
// block takes no request and pops no entry until it frees up.
// ----------------------------------------------------------------------------
module depth_sorted_sprite_batcher_unit #(
  parameter int BUFFER_DEPTH = 64,
  parameter int OCC_W        = 7
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  dsb_req_if.sink                    req_i,
  dsb_res_if.source                  res_o
);

  dsb_pkg::cmd_t    cmd;
  dsb_pkg::status_t status;

  // sequencing: request acceptance, drain loop
  dsb_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_cmd_i   (req_i.cmd),
    .status_i   (status),
    .in_ready_o (req_i.ready),
    .cmd_o      (cmd)
  );

  // sorted cells, count and result register
  dsb_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .CNT_W        (OCC_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .depth_i     (req_i.depth_key),
    .height_i    (req_i.height_key),
    .texture_i   (req_i.texture_id),
    .tag_i       (req_i.entry_tag),
    .out_ready_i (res_o.ready),
    .status_o    (status),
    .out_valid_o (res_o.valid),
    .kind_o      (res_o.kind),
    .depth_o     (res_o.out_depth),
    .height_o    (res_o.out_height),
    .texture_o   (res_o.out_texture),
    .tag_o       (res_o.out_tag),
    .run_end_o   (res_o.run_end),
    .occupancy_o (res_o.occupancy),
    .last_o      (res_o.last)
  );

endmodule
